// File: src/bns_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bns_pkg
// shared constants, codes and the pitch table of the buzzer note sequencer
// ----------------------------------------------------------------------------
package bns_pkg;

    localparam int SCORE_DEPTH_DEFAULT = 256;

    localparam int BYTE_W    = 8;
    localparam int POS_W     = 9;
    localparam int TEMPO_W   = 8;
    localparam int RELOAD_W  = 16;
    localparam int DUR_W     = 16;
    localparam int UNIT_W    = 12;
    localparam int DIV_CNT_W = 4;
    localparam int ACC_W     = 20;
    localparam int MUL_CNT_W = 3;

    localparam logic [UNIT_W-1:0]    TICK_BASE   = 12'd3750;
    localparam logic [TEMPO_W-1:0]   TEMPO_RESET = 8'd60;
    localparam logic [DUR_W-1:0]     DUR_MAX     = 16'hFFFF;

    // transaction function codes
    localparam logic [2:0] FUNC_NOTE_END = 3'd0;
    localparam logic [2:0] FUNC_PLAY     = 3'd1;
    localparam logic [2:0] FUNC_PAUSE    = 3'd2;
    localparam logic [2:0] FUNC_STOP     = 3'd3;
    localparam logic [2:0] FUNC_WRITE    = 3'd4;

    // configuration register indexes
    localparam logic CFG_TEMPO  = 1'b0;
    localparam logic CFG_LENGTH = 1'b1;

    localparam logic [RELOAD_W-1:0] PITCH_RELOAD [0:20] = '{
        16'hA885, 16'hB211, 16'hBA94, 16'hBE77, 16'hC59D, 16'hC8FD, 16'hD1AB,
        16'hD443, 16'hD909, 16'hDD4A, 16'hDF3C, 16'hE2D2, 16'hE5FE, 16'hE8D3,
        16'hEA24, 16'hEC84, 16'hEEA2, 16'hEFA1, 16'hF166, 16'hF2FF, 16'hF46C
    };

    // octave in the high nibble, note in the low nibble; anything else is a rest
    function automatic logic [RELOAD_W-1:0] tone_reload(input logic [BYTE_W-1:0] code);
        logic [3:0] oct;
        logic [3:0] note;
        logic [1:0] row;
        logic [2:0] col;
        logic [4:0] sel;
        oct  = code[7:4];
        note = code[3:0];
        row  = oct[1:0] - 2'd1;
        col  = note[2:0] - 3'd1;
        sel  = 5'(row) * 5'd7 + 5'(col);
        if (oct < 4'd1 || oct > 4'd3 || note < 4'd1 || note > 4'd7)
            return '0;
        return PITCH_RELOAD[sel];
    endfunction

endpackage
`default_nettype wire

// File: src/bns_unit_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bns_unit_div
// bit-serial restoring divider giving the tick count of one time unit
// ----------------------------------------------------------------------------
module bns_unit_div
    import bns_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [TEMPO_W-1:0] divisor,
    output logic                    busy,
    output logic [UNIT_W-1:0]       quotient
);

    logic                 run_reg, run_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [TEMPO_W-1:0]   rem_reg, rem_next;
    logic [UNIT_W-1:0]    quo_reg, quo_next;

    logic [TEMPO_W-1:0]   dvs;
    logic [TEMPO_W:0]     trial;
    logic [TEMPO_W:0]     diff;
    logic                 ge;

    // tempo zero counts as one
    assign dvs   = (divisor == '0) ? TEMPO_W'(1) : divisor;
    assign trial = {rem_reg, quo_reg[UNIT_W-1]};
    assign diff  = trial - {1'b0, dvs};
    assign ge    = (trial >= {1'b0, dvs});

    always_comb
    begin
        run_next = run_reg;
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            rem_next = '0;
            quo_next = TICK_BASE;
        end
        else if (run_reg)
        begin
            rem_next = ge ? diff[TEMPO_W-1:0] : trial[TEMPO_W-1:0];
            quo_next = {quo_reg[UNIT_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(UNIT_W - 1))
                run_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            run_reg <= run_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign busy     = run_reg | start;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

// File: src/buzzer_note_sequencer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// buzzer_note_sequencer
// plays a stored score of tone and beat byte pairs on a buzzer
// ----------------------------------------------------------------------------
// input channel (in_valid / in_stall) carries one command transaction: note
// end event, play, pause, stop or score byte write. every input transaction
// gives exactly one result transaction on the output channel (out_valid /
// out_stall) with the tone reload word, tone enable, note length, playing
// flag and the position of the next note.
// a note fetch reads the tone and beat bytes from the score memory one per
// cycle and forms the length with an 8-step shift-add multiply: it steps
// through S_TONE, S_BEAT, S_LOAD and S_MUL to S_DONE, which loads the result
// into the output register. other commands go straight to S_DONE. no new
// transaction is taken before the block is back in S_IDLE.
// the unit length (3750 / tempo) comes from a 12-step bit-serial divider
// that runs after reset and after every tempo write; in_stall stays high
// while it runs. reset clears playback state and sets tempo 60 and score
// length 0; the score memory holds no reset value. a result waits in the
// output register while out_stall is high and the next transaction may
// already be accepted; it is then held until the output register frees up.
// ----------------------------------------------------------------------------
module buzzer_note_sequencer
    import bns_pkg::*;
#(
    parameter int SCORE_DEPTH = SCORE_DEPTH_DEFAULT
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [2:0]          func,
    input  wire logic [BYTE_W-1:0]   score_addr,
    input  wire logic [BYTE_W-1:0]   score_byte,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [RELOAD_W-1:0]      reload_value,
    output logic                     tone_on,
    output logic [DUR_W-1:0]         duration_ticks,
    output logic                     playing,
    output logic [POS_W-1:0]         note_position,
    input  wire logic                cfg_write,
    input  wire logic                cfg_index,
    input  wire logic [POS_W-1:0]    cfg_data
);

    localparam int AW = $clog2(SCORE_DEPTH);
    localparam logic [AW:0] DEPTH_W = (AW+1)'(SCORE_DEPTH);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_TONE = 6'b000010,
        S_BEAT = 6'b000100,
        S_LOAD = 6'b001000,
        S_MUL  = 6'b010000,
        S_DONE = 6'b100000
    } state_t;

    function automatic logic [AW-1:0] addr_mod(input logic [BYTE_W-1:0] a);
        logic [AW:0] r;
        r = '0;
        for (int i = BYTE_W - 1; i >= 0; i--)
        begin
            r = {r[AW-1:0], a[i]};
            if (r >= DEPTH_W)
                r = r - DEPTH_W;
        end
        return r[AW-1:0];
    endfunction

    state_t                state_reg, state_next;
    logic [TEMPO_W-1:0]    tempo_reg;
    logic [POS_W-1:0]      length_reg;
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic [AW-1:0]         idx_reg, idx_next;
    logic                  active_reg, active_next;
    logic                  gap_reg, gap_next;
    logic [RELOAD_W-1:0]   reload_reg, reload_next;
    logic [DUR_W-1:0]      dur_reg, dur_next;
    logic                  sat_reg, sat_next;
    logic [BYTE_W-1:0]     mult_reg, mult_next;
    logic [ACC_W-1:0]      acc_reg, acc_next;
    logic [MUL_CNT_W-1:0]  mcnt_reg, mcnt_next;
    logic                  div_start_reg;
    logic                  div_busy;
    logic [UNIT_W-1:0]     unit;

    logic                  out_valid_reg, out_valid_next;
    logic [RELOAD_W-1:0]   out_reload_reg, out_reload_next;
    logic                  out_tone_reg, out_tone_next;
    logic [DUR_W-1:0]      out_dur_reg, out_dur_next;
    logic                  out_play_reg, out_play_next;
    logic [POS_W-1:0]      out_pos_reg, out_pos_next;

    logic [BYTE_W-1:0]     score_mem [SCORE_DEPTH];
    logic [BYTE_W-1:0]     mem_q_reg;
    logic [AW-1:0]         raddr;
    logic [AW-1:0]         idx_plus1;
    logic [AW-1:0]         waddr;
    logic                  mem_we;

    logic                  in_take;
    logic                  fetch;
    logic [POS_W:0]        pos_sum;
    logic [AW:0]           idx_sum;

    bns_unit_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .divisor  (tempo_reg),
        .busy     (div_busy),
        .quotient (unit)
    );

    assign in_stall = (state_reg != S_IDLE) || div_start_reg || div_busy;
    assign in_take  = in_valid && !in_stall;
    assign fetch    = (pos_reg < length_reg) && active_reg && !gap_reg;

    assign idx_plus1 = (idx_reg == AW'(SCORE_DEPTH - 1)) ? '0 : idx_reg + 1'b1;
    assign raddr     = (state_reg == S_TONE) ? idx_reg : idx_plus1;
    assign waddr     = addr_mod(score_addr);
    assign mem_we    = in_take && (func == FUNC_WRITE);

    assign pos_sum = {1'b0, pos_reg} + (POS_W+1)'(2);
    assign idx_sum = {1'b0, idx_reg} + (AW+1)'(2);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tempo_reg     <= TEMPO_RESET;
            length_reg    <= '0;
            div_start_reg <= 1'b1;
        end
        else
        begin
            div_start_reg <= cfg_write && (cfg_index == CFG_TEMPO);
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_TEMPO:  tempo_reg  <= cfg_data[TEMPO_W-1:0];
                    CFG_LENGTH: length_reg <= cfg_data;
                    default:    tempo_reg  <= tempo_reg;
                endcase
            end
        end
    end

    // score memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
            score_mem[waddr] <= score_byte;
        mem_q_reg <= score_mem[raddr];
    end

    always_comb
    begin
        state_next      = state_reg;
        pos_next        = pos_reg;
        idx_next        = idx_reg;
        active_next     = active_reg;
        gap_next        = gap_reg;
        reload_next     = reload_reg;
        dur_next        = dur_reg;
        sat_next        = sat_reg;
        mult_next       = mult_reg;
        acc_next        = acc_reg;
        mcnt_next       = mcnt_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_reload_next = out_reload_reg;
        out_tone_next   = out_tone_reg;
        out_dur_next    = out_dur_reg;
        out_play_next   = out_play_reg;
        out_pos_next    = out_pos_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    state_next = S_DONE;
                    unique case (func)
                        FUNC_NOTE_END:
                        begin
                            if (fetch)
                                state_next = S_TONE;
                            else if (gap_reg)
                            begin
                                gap_next    = 1'b0;
                                reload_next = '0;
                                dur_next    = DUR_W'(unit);
                            end
                            else
                            begin
                                active_next = 1'b0;
                                pos_next    = '0;
                                idx_next    = '0;
                                reload_next = '0;
                                dur_next    = '0;
                            end
                        end
                        FUNC_PLAY:
                        begin
                            if (!active_reg)
                            begin
                                active_next = 1'b1;
                                dur_next    = '0;
                            end
                        end
                        FUNC_PAUSE:
                        begin
                            active_next = 1'b0;
                            reload_next = '0;
                        end
                        FUNC_STOP:
                        begin
                            active_next = 1'b0;
                            pos_next    = '0;
                            idx_next    = '0;
                            reload_next = '0;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_TONE:
            begin
                state_next = S_BEAT;
            end
            S_BEAT:
            begin
                reload_next = tone_reload(mem_q_reg);
                state_next  = S_LOAD;
            end
            S_LOAD:
            begin
                // beat zero gives length zero
                mult_next = (mem_q_reg == '0) ? '0 : mem_q_reg - 1'b1;
                acc_next  = '0;
                mcnt_next = '0;
                sat_next  = 1'b0;
                gap_next  = 1'b1;
                pos_next  = pos_sum[POS_W-1:0];
                if (pos_sum[POS_W])
                    idx_next = AW'(pos_sum[POS_W-1:0]);
                else if (idx_sum >= DEPTH_W)
                    idx_next = AW'(idx_sum - DEPTH_W);
                else
                    idx_next = idx_sum[AW-1:0];
                state_next = S_MUL;
            end
            S_MUL:
            begin
                if (sat_reg)
                begin
                    dur_next   = (acc_reg > ACC_W'(DUR_MAX)) ? DUR_MAX : acc_reg[DUR_W-1:0];
                    state_next = S_DONE;
                end
                else
                begin
                    acc_next  = {acc_reg[ACC_W-2:0], 1'b0}
                              + (mult_reg[BYTE_W-1] ? ACC_W'(unit) : '0);
                    mult_next = {mult_reg[BYTE_W-2:0], 1'b0};
                    mcnt_next = mcnt_reg + 1'b1;
                    if (mcnt_reg == MUL_CNT_W'(BYTE_W - 1))
                        sat_next = 1'b1;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_reload_next = reload_reg;
                    out_tone_next   = (reload_reg != '0);
                    out_dur_next    = dur_reg;
                    out_play_next   = active_reg;
                    out_pos_next    = pos_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pos_reg       <= '0;
            idx_reg       <= '0;
            active_reg    <= 1'b0;
            gap_reg       <= 1'b0;
            reload_reg    <= '0;
            dur_reg       <= '0;
            sat_reg       <= 1'b0;
            mcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            idx_reg       <= idx_next;
            active_reg    <= active_next;
            gap_reg       <= gap_next;
            reload_reg    <= reload_next;
            dur_reg       <= dur_next;
            sat_reg       <= sat_next;
            mcnt_reg      <= mcnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mult_reg       <= mult_next;
        acc_reg        <= acc_next;
        out_reload_reg <= out_reload_next;
        out_tone_reg   <= out_tone_next;
        out_dur_reg    <= out_dur_next;
        out_play_reg   <= out_play_next;
        out_pos_reg    <= out_pos_next;
    end

    assign out_valid      = out_valid_reg;
    assign reload_value   = out_reload_reg;
    assign tone_on        = out_tone_reg;
    assign duration_ticks = out_dur_reg;
    assign playing        = out_play_reg;
    assign note_position  = out_pos_reg;

    // notes are two bytes, so the read position stays even
    a_pos_even: assert property (@(posedge clk) disable iff (!rst_n)
        !pos_reg[0])
        else $error("read position odd");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, idx_reg} < DEPTH_W))
        else $error("score index beyond memory depth");

    a_div_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        div_busy |-> in_stall)
        else $error("transaction accepted while unit length is computed");

    a_fetch_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOAD) |=> (gap_reg && state_reg == S_MUL))
        else $error("note fetch did not arm the gap");

endmodule
`default_nettype wire

// File: bench/buzzer_note_sequencer_check.sv
// ----------------------------------------------------------------------------
// buzzer_note_sequencer_check
// watches both channels and the register port of the buzzer note sequencer
// ----------------------------------------------------------------------------
// keeps its own copy of the score, the playback state and the two registers.
// each accepted command transaction is played through that copy and the note
// result it gives is queued. each accepted result transaction is compared
// field by field with the oldest queued note. the number of queued notes and
// the number of mismatches go back to the testbench top.
// ----------------------------------------------------------------------------
module buzzer_note_sequencer_check
    import bns_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic                in_stall,
    input  wire logic [2:0]          func,
    input  wire logic [BYTE_W-1:0]   score_addr,
    input  wire logic [BYTE_W-1:0]   score_byte,
    input  wire logic                out_valid,
    input  wire logic                out_stall,
    input  wire logic [RELOAD_W-1:0] reload_value,
    input  wire logic                tone_on,
    input  wire logic [DUR_W-1:0]    duration_ticks,
    input  wire logic                playing,
    input  wire logic [POS_W-1:0]    note_position,
    input  wire logic                cfg_write,
    input  wire logic                cfg_index,
    input  wire logic [POS_W-1:0]    cfg_data,
    output int                       notes_due,
    output int                       mismatches
);

    typedef struct packed {
        logic [RELOAD_W-1:0] reload;
        logic                tone;
        logic [DUR_W-1:0]    ticks;
        logic                active;
        logic [POS_W-1:0]    pos;
    } note_result_t;

    // octave 1..3 by row, note 1..7 by column
    localparam logic [RELOAD_W-1:0] PITCH_WORD [0:20] = '{
        16'hA885, 16'hB211, 16'hBA94, 16'hBE77, 16'hC59D, 16'hC8FD, 16'hD1AB,
        16'hD443, 16'hD909, 16'hDD4A, 16'hDF3C, 16'hE2D2, 16'hE5FE, 16'hE8D3,
        16'hEA24, 16'hEC84, 16'hEEA2, 16'hEFA1, 16'hF166, 16'hF2FF, 16'hF46C
    };

    logic [BYTE_W-1:0]   score_copy [0:255];
    logic [POS_W-1:0]    next_pos;
    logic                active;
    logic                gap_due;
    logic [RELOAD_W-1:0] tone_word;
    logic [DUR_W-1:0]    length_ticks;
    logic [TEMPO_W-1:0]  tempo_set;
    logic [POS_W-1:0]    length_set;
    note_result_t        due_notes [$];
    int                  bad_count = 0;

    function automatic int unsigned unit_len(input logic [TEMPO_W-1:0] tempo);
        return 3750 / ((tempo == '0) ? 1 : int'(tempo));
    endfunction

    function automatic logic [RELOAD_W-1:0] pitch_word(input logic [BYTE_W-1:0] code);
        int unsigned oct;
        int unsigned note;
        oct  = code[7:4];
        note = code[3:0];
        if (oct < 1 || oct > 3 || note < 1 || note > 7)
            return '0;
        return PITCH_WORD[(oct - 1) * 7 + (note - 1)];
    endfunction

    // one note end event: fetch a pair, close a note with a gap, or stop
    task automatic end_of_note();
        logic [BYTE_W-1:0] code;
        logic [BYTE_W-1:0] beat_at;
        int unsigned       beat;
        int unsigned       span;
        if (next_pos < length_set && active && !gap_due)
        begin
            beat_at = next_pos[7:0] + 8'd1;
            code = score_copy[next_pos[7:0]];
            beat = score_copy[beat_at];
            next_pos = next_pos + 9'd2;
            tone_word = pitch_word(code);
            span = (beat == 0) ? 0 : (beat - 1) * unit_len(tempo_set);
            length_ticks = (span > 65535) ? DUR_MAX : span[15:0];
            gap_due = 1'b1;
        end
        else if (gap_due)
        begin
            gap_due = 1'b0;
            tone_word = '0;
            length_ticks = 16'(unit_len(tempo_set));
        end
        else
        begin
            active = 1'b0;
            next_pos = '0;
            tone_word = '0;
            length_ticks = '0;
        end
    endtask

    task automatic play_command(input logic [2:0] code, input logic [BYTE_W-1:0] addr,
                                input logic [BYTE_W-1:0] data, output note_result_t res);
        case (code)
            FUNC_NOTE_END: end_of_note();
            FUNC_PLAY:
                if (!active)
                begin
                    active = 1'b1;
                    length_ticks = '0;
                end
            FUNC_PAUSE:
            begin
                active = 1'b0;
                tone_word = '0;
            end
            FUNC_STOP:
            begin
                active = 1'b0;
                next_pos = '0;
                tone_word = '0;
            end
            FUNC_WRITE: score_copy[addr] = data;
            default: ;
        endcase
        res = {tone_word, tone_word != '0, length_ticks, active, next_pos};
    endtask

    always @(posedge clk)
    begin
        note_result_t got;
        note_result_t want;
        note_result_t fresh;
        if (!rst_n)
        begin
            next_pos     = '0;
            active       = 1'b0;
            gap_due      = 1'b0;
            tone_word    = '0;
            length_ticks = '0;
            tempo_set    = TEMPO_RESET;
            length_set   = '0;
            due_notes.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got = {reload_value, tone_on, duration_ticks, playing, note_position};
                if (due_notes.size() == 0)
                begin
                    bad_count++;
                    if (bad_count <= 10)
                        $display("result transaction with nothing due: reload %h ticks %0d pos %0d",
                                 reload_value, duration_ticks, note_position);
                end
                else
                begin
                    want = due_notes.pop_front();
                    if (got.reload !== want.reload || got.tone !== want.tone
                        || got.ticks !== want.ticks || got.active !== want.active
                        || got.pos !== want.pos)
                    begin
                        bad_count++;
                        if (bad_count <= 10)
                        begin
                            $write("note mismatch (expected/actual): reload %h/%h tone %b/%b ",
                                   want.reload, got.reload, want.tone, got.tone);
                            $display("ticks %0d/%0d playing %b/%b pos %0d/%0d",
                                     want.ticks, got.ticks, want.active, got.active,
                                     want.pos, got.pos);
                        end
                    end
                end
            end
            if (cfg_write)
            begin
                if (cfg_index == CFG_TEMPO)
                    tempo_set = cfg_data[TEMPO_W-1:0];
                else
                    length_set = cfg_data;
            end
            if (in_valid && !in_stall)
            begin
                play_command(func, score_addr, score_byte, fresh);
                due_notes.push_back(fresh);
            end
        end
        notes_due  <= due_notes.size();
        mismatches <= bad_count;
    end

endmodule

// File: bench/buzzer_note_sequencer_test.sv
// ----------------------------------------------------------------------------
// buzzer_note_sequencer_test
// stimulus and verdict for the buzzer note sequencer
// ----------------------------------------------------------------------------
// a short directed run covers the pitch table ends, beat zero and 255, rests,
// pause with a gap still due, play while playing, stop and the spare
// function codes. random phases then play short phrases of note end events
// mixed with score writes and commands, each phase with its own tempo, score
// length and idling pattern. registers change only with the block idle, and
// the score is always loaded before the length lets playback reach it.
// ----------------------------------------------------------------------------
module buzzer_note_sequencer_test;
    import bns_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASE_ITEMS    = 160;
    localparam int PHASES         = 8;

    localparam logic [2:0] FUNC_SPARE_5 = 3'd5;
    localparam logic [2:0] FUNC_SPARE_6 = 3'd6;
    localparam logic [2:0] FUNC_SPARE_7 = 3'd7;

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                in_valid     = 1'b0;
    logic [2:0]          func         = FUNC_NOTE_END;
    logic [BYTE_W-1:0]   score_addr   = '0;
    logic [BYTE_W-1:0]   score_byte   = '0;
    logic                out_stall    = 1'b0;
    logic                cfg_write    = 1'b0;
    logic                cfg_index    = CFG_TEMPO;
    logic [POS_W-1:0]    cfg_data     = '0;
    wire logic                in_stall;
    wire logic                out_valid;
    wire logic [RELOAD_W-1:0] reload_value;
    wire logic                tone_on;
    wire logic [DUR_W-1:0]    duration_ticks;
    wire logic                playing;
    wire logic [POS_W-1:0]    note_position;

    int notes_due;
    int mismatches;
    int gap_pct   = 0;
    int stall_pct = 0;
    int sent      = 0;
    int quiet     = 0;
    bit loaded [0:255];

    int tempo_plan  [PHASES] = '{255, 1, 60, 0, 60, 2, 60, 128};
    int length_plan [PHASES] = '{256, 256, 40, 255, 0, 0, 0, 7};

    buzzer_note_sequencer u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .func           (func),
        .score_addr     (score_addr),
        .score_byte     (score_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .reload_value   (reload_value),
        .tone_on        (tone_on),
        .duration_ticks (duration_ticks),
        .playing        (playing),
        .note_position  (note_position),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    buzzer_note_sequencer_check u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .func           (func),
        .score_addr     (score_addr),
        .score_byte     (score_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .reload_value   (reload_value),
        .tone_on        (tone_on),
        .duration_ticks (duration_ticks),
        .playing        (playing),
        .note_position  (note_position),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .notes_due      (notes_due),
        .mismatches     (mismatches)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
        out_stall <= ($urandom_range(0, 99) < stall_pct);

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet <= 0;
        else if (quiet >= WATCHDOG_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    // mostly playable tone codes, then short beats, then anything
    function automatic logic [BYTE_W-1:0] score_value();
        int unsigned pick;
        pick = $urandom_range(0, 3);
        if (pick < 2)
            return {4'($urandom_range(1, 3)), 4'($urandom_range(1, 7))};
        if (pick == 2)
            return 8'($urandom_range(0, 24));
        return 8'($urandom);
    endfunction

    task automatic send(input logic [2:0] code, input logic [BYTE_W-1:0] addr,
                        input logic [BYTE_W-1:0] data);
        while ($urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        func       <= code;
        score_addr <= addr;
        score_byte <= data;
        if (code == FUNC_WRITE)
            loaded[addr] = 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (notes_due != 0 || in_stall)
            @(posedge clk);
    endtask

    // fill every byte that playback up to this length can read, then idle and write
    task automatic set_registers(input logic [POS_W-1:0] len, input logic [TEMPO_W-1:0] tempo);
        int span;
        span = (int'(len) + 1) / 2 * 2;
        for (int i = 0; i < span; i++)
            if (!loaded[i])
                send(FUNC_WRITE, 8'(i), score_value());
        drain();
        cfg_write <= 1'b1;
        cfg_index <= CFG_LENGTH;
        cfg_data  <= len;
        @(posedge clk);
        cfg_index <= CFG_TEMPO;
        cfg_data  <= {1'b0, tempo};
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        int pick;
        int run;
        int phase_end;
        logic [TEMPO_W-1:0] tempo;
        logic [POS_W-1:0]   len;

        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings, nothing loaded
        send(FUNC_NOTE_END, 8'h00, 8'h00);
        send(FUNC_PLAY, 8'hFF, 8'hFF);
        send(FUNC_PLAY, 8'h00, 8'hFF);
        send(FUNC_NOTE_END, 8'hFF, 8'h00);
        send(FUNC_WRITE, 8'd0, 8'h11);
        send(FUNC_WRITE, 8'd1, 8'h00);
        send(FUNC_WRITE, 8'd2, 8'h37);
        send(FUNC_WRITE, 8'd3, 8'hFF);
        send(FUNC_WRITE, 8'd4, 8'h48);
        send(FUNC_WRITE, 8'd5, 8'h01);
        send(FUNC_WRITE, 8'd6, 8'h30);
        send(FUNC_WRITE, 8'd7, 8'h02);
        send(FUNC_WRITE, 8'hFF, 8'hFF);

        // slowest unit, so beat 255 saturates
        set_registers(9'd8, 8'd1);
        send(FUNC_PLAY, 8'h00, 8'h00);
        send(FUNC_NOTE_END, 8'h00, 8'h00);
        send(FUNC_NOTE_END, 8'h00, 8'h00);
        send(FUNC_NOTE_END, 8'h00, 8'h00);
        send(FUNC_PAUSE, 8'h00, 8'h00);
        send(FUNC_NOTE_END, 8'h00, 8'h00);
        send(FUNC_PLAY, 8'h00, 8'h00);
        send(FUNC_NOTE_END, 8'h00, 8'h00);
        send(FUNC_STOP, 8'h00, 8'h00);
        send(FUNC_SPARE_5, 8'hAA, 8'h55);
        send(FUNC_SPARE_6, 8'h55, 8'hAA);
        send(FUNC_SPARE_7, 8'hFF, 8'hFF);
        send(FUNC_NOTE_END, 8'h00, 8'h00);
        send(FUNC_NOTE_END, 8'h00, 8'h00);

        for (int p = 0; p < PHASES; p++)
        begin
            case (p % 4)
                0:       begin gap_pct = 0;  stall_pct = 0;  end
                1:       begin gap_pct = 77; stall_pct = 0;  end
                2:       begin gap_pct = 0;  stall_pct = 77; end
                default: begin gap_pct = 34; stall_pct = 34; end
            endcase
            tempo = 8'(tempo_plan[p]);
            len   = 9'(length_plan[p]);
            if (p == 4 || p == 6)
            begin
                tempo = 8'($urandom_range(1, 255));
                len   = 9'($urandom_range(0, 256));
            end
            set_registers(len, tempo);
            phase_end = sent + PHASE_ITEMS;
            while (sent < phase_end)
            begin
                send(FUNC_PLAY, 8'($urandom), 8'($urandom));
                run = $urandom_range(4, 40);
                repeat (run)
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 78)
                        send(FUNC_NOTE_END, 8'($urandom), 8'($urandom));
                    else if (pick < 88)
                        send(FUNC_WRITE, 8'($urandom), score_value());
                    else if (pick < 92)
                        send(FUNC_PAUSE, 8'($urandom), 8'($urandom));
                    else if (pick < 94)
                        send(FUNC_STOP, 8'($urandom), 8'($urandom));
                    else if (pick < 97)
                        send(FUNC_PLAY, 8'($urandom), 8'($urandom));
                    else
                        send(FUNC_SPARE_5 + 3'($urandom_range(0, 2)), 8'($urandom),
                             8'($urandom));
                end
            end
        end

        drain();
        repeat (40)
            @(posedge clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
